// File: sv/three_digit_lock_code_entry_unit_defines.svh
// Assertion macros for the lock code entry unit.
`ifndef THREE_DIGIT_LOCK_CODE_ENTRY_UNIT_DEFINES_SVH
`define THREE_DIGIT_LOCK_CODE_ENTRY_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define TDL_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdl: implication check failed");
`define TDL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdl: next-cycle check failed");
`else
`define TDL_ASSERT_IMPL(label, clk, rst, ante, cons)
`define TDL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: sv/tdl_pkg.sv
// Shared types, constants and tables of the lock code entry unit.
`timescale 1ns / 1ps
package tdl_pkg;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PROMPT_DELAY = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_DELAY  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_REPEAT_DELAY = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLINK_DELAY  = 2'd3;

   localparam logic [15:0] RST_PROMPT_DELAY = 16'd1000;
   localparam logic [15:0] RST_ENTRY_DELAY  = 16'd1000;
   localparam logic [15:0] RST_REPEAT_DELAY = 16'd500;
   localparam logic [15:0] RST_BLINK_DELAY  = 16'd150;

   localparam logic [15:0] PW_ENABLE_CHORD  = 16'he100;
   localparam logic [15:0] PW_DISABLE_CHORD = 16'he800;
   localparam logic [7:0]  AD_COMMON_CHORD  = 8'h16;
   localparam logic [15:0] PW_INC    = 16'h0100;
   localparam logic [15:0] PW_PREV   = 16'h0200;
   localparam logic [15:0] PW_NEXT   = 16'h0400;
   localparam logic [15:0] PW_DEC    = 16'h0800;
   localparam logic [15:0] PW_CANCEL = 16'h1000;
   localparam logic [15:0] SW_CONFIRM = 16'h0200;
   localparam logic [15:0] SW_CANCEL  = 16'h0800;
   localparam logic [7:0]  AD0_INC  = 8'h01;
   localparam logic [7:0]  AD0_PREV = 8'h02;
   localparam logic [7:0]  AD0_NEXT = 8'h04;
   localparam logic [7:0]  AD0_DEC  = 8'h08;
   localparam logic [7:0]  AD2_CANCEL  = 8'h04;
   localparam logic [7:0]  AD2_CONFIRM = 8'h08;

   localparam logic [7:0] WK_MODE_06 = 8'h06;
   localparam logic [7:0] WK_MODE_0A = 8'h0a;
   localparam logic [7:0] WK_MODE_0C = 8'h0c;
   localparam logic [7:0] WK_MODE_0F = 8'h0f;
   localparam logic [7:0] WK_MODE_15 = 8'h15;
   localparam logic [7:0] WK_MODE_17 = 8'h17;
   localparam logic [7:0] WK_MODE_1C = 8'h1c;

   localparam logic [6:0] GLYPH_L = 7'h38;
   localparam logic [6:0] GLYPH_O = 7'h3f;
   localparam logic [6:0] GLYPH_C = 7'h39;

   localparam logic [4:0] CMD_NONE    = 5'h00;
   localparam logic [4:0] CMD_ENABLE  = 5'h1e;
   localparam logic [4:0] CMD_DISABLE = 5'h1f;

   localparam logic [1:0] SHOW_NONE   = 2'd0;
   localparam logic [1:0] SHOW_PROMPT = 2'd1;
   localparam logic [1:0] SHOW_DIGITS = 2'd2;
   localparam logic [1:0] SHOW_CLEAR  = 2'd3;

   typedef enum logic [4:0] {
      PH_IDLE    = 5'b00001,
      PH_PREPARE = 5'b00010,
      PH_WAIT    = 5'b00100,
      PH_EDIT    = 5'b01000,
      PH_CONFIRM = 5'b10000
   } phase_type;

   typedef struct packed {
      logic [31:0] time_ms;
      logic        en_chord;
      logic        dis_chord;
      logic        inc;
      logic        dec;
      logic        prv;
      logic        nxt;
      logic        finish;
      logic        blank_prompt;
      logic        native;
      logic        report_path;
   } cls_type;

   function automatic logic [6:0] seg_glyph(input logic [3:0] d);
      logic [6:0] g;
      case (d)
         4'd0: g = 7'h3f;
         4'd1: g = 7'h06;
         4'd2: g = 7'h5b;
         4'd3: g = 7'h4f;
         4'd4: g = 7'h66;
         4'd5: g = 7'h6d;
         4'd6: g = 7'h7d;
         4'd7: g = 7'h07;
         4'd8: g = 7'h7f;
         4'd9: g = 7'h6f;
         default: g = 7'h00;
      endcase
      return g;
   endfunction

   function automatic logic [5:0] sel_report(input logic [1:0] s);
      logic [5:0] r;
      case (s)
         2'd0: r = 6'h20;
         2'd1: r = 6'h10;
         2'd2: r = 6'h08;
         default: r = 6'h00;
      endcase
      return r;
   endfunction

endpackage

// File: sv/tdl_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps
interface tdl_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] time_ms;
   logic [15:0] primary_word;
   logic [15:0] secondary_word;
   logic        adapter_present;
   logic [7:0]  adapter_byte0;
   logic [7:0]  adapter_byte1;
   logic [7:0]  adapter_byte2;
   logic [7:0]  wheel_kind;
   modport source (output valid, time_ms, primary_word, secondary_word, adapter_present,
                   adapter_byte0, adapter_byte1, adapter_byte2, wheel_kind,
                   input ready);
   modport sink (input valid, time_ms, primary_word, secondary_word, adapter_present,
                 adapter_byte0, adapter_byte1, adapter_byte2, wheel_kind,
                 output ready);
endinterface

interface tdl_rsp_if;
   logic        valid;
   logic        ready;
   logic        busy_res;
   logic [1:0]  show_kind;
   logic [6:0]  glyph_first;
   logic [6:0]  glyph_second;
   logic [6:0]  glyph_third;
   logic [5:0]  select_report;
   logic [4:0]  native_command;
   logic        saved_changed;
   logic        code_mismatch;
   logic        lock_on;
   logic [11:0] lock_code;
   modport source (output valid, busy_res, show_kind, glyph_first, glyph_second, glyph_third,
                   select_report, native_command, saved_changed, code_mismatch, lock_on,
                   lock_code, input ready);
   modport sink (input valid, busy_res, show_kind, glyph_first, glyph_second, glyph_third,
                 select_report, native_command, saved_changed, code_mismatch, lock_on,
                 lock_code, output ready);
endinterface

// File: sv/three_digit_lock_code_entry_unit.sv
// Top level of the three-digit lock code entry unit.
// Usage:
//   req_chan carries one service pass per beat: time, wheel button words,
//   adapter bytes and wheel mode. rsp_chan returns exactly one beat per
//   request beat, in order, with the display, report, command and lock state.
//   csr_we/csr_index/csr_wdata write the four delay registers (prompt, entry,
//   repeat, blink), by the user only while no pass is outstanding (unchecked).
// Timing:
//   A request beat is decoded combinationally into a two-entry queue; the
//   sequencer pops it when the response register is free or being read, and
//   its response is registered. Throughput is one beat per cycle while
//   rsp_chan.ready stays high.
// Reset (synchronous, active high): lock off, stored code 000, delays at
//   their defaults, queue and response register empty.
// Stall: while rsp_chan.ready is low the response register holds; the queue
//   fills both of its entries before req_chan.ready drops.
`timescale 1ns / 1ps
module three_digit_lock_code_entry_unit import tdl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   tdl_req_if.sink                req_chan,
   tdl_rsp_if.source              rsp_chan,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic    enq_valid, enq_ready;
   cls_type enq_data;
   logic    deq_valid, deq_ready;
   cls_type deq_data;

   tdl_front u_front (
      .req       (req_chan),
      .enq_valid (enq_valid),
      .enq_data  (enq_data),
      .enq_ready (enq_ready)
   );

   tdl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .enq_valid (enq_valid),
      .enq_ready (enq_ready),
      .enq_data  (enq_data),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_data  (deq_data)
   );

   tdl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .deq_valid (deq_valid),
      .deq_ready (deq_ready),
      .deq_data  (deq_data),
      .rsp       (rsp_chan)
   );

endmodule

// File: sv/tdl_front.sv
// Front end: decodes one request beat into chord and action flags.
`timescale 1ns / 1ps
module tdl_front import tdl_pkg::*; (
   tdl_req_if.sink req,
   output logic    enq_valid,
   output cls_type enq_data,
   input  logic    enq_ready
);

   logic common;
   logic alt_cancel;
   logic cnf;
   logic cnc;

   assign req.ready = enq_ready;
   assign enq_valid = req.valid;

   assign common = req.adapter_present &&
                   ((req.adapter_byte1 & AD_COMMON_CHORD) == AD_COMMON_CHORD);
   assign alt_cancel = (req.wheel_kind == WK_MODE_06) || (req.wheel_kind == WK_MODE_15);

   always_comb begin
      enq_data.time_ms   = req.time_ms;
      enq_data.en_chord  = ((req.primary_word & PW_ENABLE_CHORD) == PW_ENABLE_CHORD) ||
                           (common && ((req.adapter_byte0 & AD0_INC) != 8'h00));
      enq_data.dis_chord = ((req.primary_word & PW_DISABLE_CHORD) == PW_DISABLE_CHORD) ||
                           (common && ((req.adapter_byte0 & AD0_DEC) != 8'h00));
      if (req.adapter_present) begin
         enq_data.inc = (req.adapter_byte0 & AD0_INC) != 8'h00;
         enq_data.dec = (req.adapter_byte0 & AD0_DEC) != 8'h00;
         enq_data.prv = (req.adapter_byte0 & AD0_PREV) != 8'h00;
         enq_data.nxt = (req.adapter_byte0 & AD0_NEXT) != 8'h00;
         cnf = (req.adapter_byte2 & AD2_CONFIRM) != 8'h00;
         cnc = (req.adapter_byte2 & AD2_CANCEL) != 8'h00;
      end else begin
         enq_data.inc = (req.primary_word & PW_INC) != 16'h0000;
         enq_data.dec = (req.primary_word & PW_DEC) != 16'h0000;
         enq_data.prv = (req.primary_word & PW_PREV) != 16'h0000;
         enq_data.nxt = (req.primary_word & PW_NEXT) != 16'h0000;
         cnf = (req.secondary_word & SW_CONFIRM) != 16'h0000;
         cnc = alt_cancel ? ((req.primary_word & PW_CANCEL) != 16'h0000)
                          : ((req.secondary_word & SW_CANCEL) != 16'h0000);
      end
      enq_data.finish       = cnf || cnc;
      enq_data.blank_prompt = req.wheel_kind == WK_MODE_0C;
      enq_data.native       = (req.wheel_kind == WK_MODE_0C) || alt_cancel;
      enq_data.report_path  = req.adapter_present || (req.wheel_kind == WK_MODE_0A) ||
                              (req.wheel_kind == WK_MODE_0C) || (req.wheel_kind == WK_MODE_0F) ||
                              (req.wheel_kind == WK_MODE_17) || (req.wheel_kind == WK_MODE_1C);
   end

endmodule

// File: sv/tdl_queue.sv
// Two-entry queue between the decode front and the sequencer.
`timescale 1ns / 1ps
module tdl_queue import tdl_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    enq_valid,
   output logic    enq_ready,
   input  cls_type enq_data,
   output logic    deq_valid,
   input  logic    deq_ready,
   output cls_type deq_data
);

   cls_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign enq_ready = count_ff != 2'd2;
   assign deq_valid = count_ff != 2'd0;
   assign deq_data  = slot_ff[rd_ptr_ff];
   assign push      = enq_valid && enq_ready;
   assign pop       = deq_valid && deq_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= enq_data;
      end
   end

endmodule

// File: sv/tdl_back.sv
// Sequencer: lock state, code entry, timers and the registered response.
`timescale 1ns / 1ps
`include "three_digit_lock_code_entry_unit_defines.svh"
module tdl_back import tdl_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   input  logic                   deq_valid,
   output logic                   deq_ready,
   input  cls_type                deq_data,
   tdl_rsp_if.source              rsp
);

   typedef struct packed {
      logic        busy_res;
      logic [1:0]  show_kind;
      logic [6:0]  glyph_first;
      logic [6:0]  glyph_second;
      logic [6:0]  glyph_third;
      logic [5:0]  select_report;
      logic [4:0]  native_command;
      logic        saved_changed;
      logic        code_mismatch;
      logic        lock_on;
      logic [11:0] lock_code;
   } res_type;

   logic [15:0] prompt_dly_ff, entry_dly_ff, repeat_dly_ff, blink_dly_ff;

   phase_type   phase_ff, phase_in;
   logic        enabling_ff, enabling_in;
   logic [3:0]  entered_ff [3];
   logic [3:0]  entered_in [3];
   logic [1:0]  cursor_ff, cursor_in;
   logic [31:0] action_dl_ff, action_dl_in;
   logic [31:0] blink_dl_ff, blink_dl_in;
   logic [2:0]  blink_step_ff, blink_step_in;
   logic        locked_ff, locked_in;
   logic [3:0]  saved_ff [3];
   logic [3:0]  saved_in [3];

   res_type     res_ff, res_in;
   logic        out_valid_ff;
   logic        pop;
   logic        code_match;
   logic        en_pop;
   logic        bad_pop;

   function automatic logic reached(input logic [31:0] now, input logic [31:0] dl);
      logic [31:0] diff;
      diff = now - dl;
      return ~diff[31];
   endfunction

   assign deq_ready  = !out_valid_ff || rsp.ready;
   assign pop        = deq_valid && deq_ready;
   assign code_match = (saved_ff[0] == entered_ff[0]) && (saved_ff[1] == entered_ff[1]) &&
                       (saved_ff[2] == entered_ff[2]);
   assign en_pop     = pop && (phase_ff == PH_CONFIRM) && enabling_ff;
   assign bad_pop    = pop && (phase_ff == PH_CONFIRM) && !enabling_ff && !code_match;

   always_ff @(posedge clock) begin
      if (reset) begin
         prompt_dly_ff <= RST_PROMPT_DELAY;
         entry_dly_ff  <= RST_ENTRY_DELAY;
         repeat_dly_ff <= RST_REPEAT_DELAY;
         blink_dly_ff  <= RST_BLINK_DELAY;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PROMPT_DELAY: prompt_dly_ff <= csr_wdata;
            CSR_ENTRY_DELAY:  entry_dly_ff  <= csr_wdata;
            CSR_REPEAT_DELAY: repeat_dly_ff <= csr_wdata;
            CSR_BLINK_DELAY:  blink_dly_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      logic [31:0] now;
      logic [1:0]  sel;
      logic [3:0]  digit;
      logic [3:0]  digit_new;
      logic        act_hit;
      logic        moving;
      logic [6:0]  g [3];
      now           = deq_data.time_ms;
      sel           = cursor_ff;
      phase_in      = phase_ff;
      enabling_in   = enabling_ff;
      entered_in    = entered_ff;
      cursor_in     = cursor_ff;
      action_dl_in  = action_dl_ff;
      blink_dl_in   = blink_dl_ff;
      blink_step_in = blink_step_ff;
      locked_in     = locked_ff;
      saved_in      = saved_ff;
      res_in        = '0;
      g[0]          = 7'h00;
      g[1]          = 7'h00;
      g[2]          = 7'h00;
      act_hit       = reached(now, action_dl_ff);
      moving        = deq_data.inc || deq_data.dec || deq_data.prv || deq_data.nxt;
      case (sel)
         2'd0: digit = entered_ff[0];
         2'd1: digit = entered_ff[1];
         2'd2: digit = entered_ff[2];
         default: digit = 4'd0;
      endcase
      if (deq_data.inc) begin
         digit_new = (digit >= 4'd9) ? 4'd0 : digit + 4'd1;
      end else begin
         digit_new = (digit == 4'd0) ? 4'd9 : digit - 4'd1;
      end

      case (phase_ff)
         PH_IDLE: begin
            if (!locked_ff && deq_data.en_chord) begin
               enabling_in = 1'b1;
               phase_in    = PH_PREPARE;
            end else if (locked_ff && deq_data.dis_chord) begin
               enabling_in = 1'b0;
               phase_in    = PH_PREPARE;
            end
         end
         PH_PREPARE: begin
            res_in.busy_res  = 1'b1;
            res_in.show_kind = SHOW_PROMPT;
            action_dl_in     = now + {16'h0000, prompt_dly_ff};
            phase_in         = PH_WAIT;
            if (!deq_data.blank_prompt) begin
               g[0] = GLYPH_L;
               g[1] = GLYPH_O;
               g[2] = GLYPH_C;
            end
            if (deq_data.native) begin
               res_in.native_command = enabling_ff ? CMD_ENABLE : CMD_DISABLE;
            end
         end
         PH_WAIT: begin
            res_in.busy_res = 1'b1;
            if (act_hit) begin
               entered_in[0] = 4'd0;
               entered_in[1] = 4'd0;
               entered_in[2] = 4'd0;
               cursor_in     = 2'd0;
               action_dl_in  = now + {16'h0000, entry_dly_ff};
               phase_in      = PH_EDIT;
            end
         end
         PH_EDIT: begin
            res_in.busy_res  = 1'b1;
            res_in.show_kind = SHOW_DIGITS;
            if (act_hit) begin
               if (deq_data.inc || deq_data.dec) begin
                  case (sel)
                     2'd0: entered_in[0] = digit_new;
                     2'd1: entered_in[1] = digit_new;
                     2'd2: entered_in[2] = digit_new;
                     default: ;
                  endcase
               end else if (deq_data.prv) begin
                  cursor_in = (sel == 2'd0) ? 2'd2 : sel - 2'd1;
               end else if (deq_data.nxt) begin
                  cursor_in = (sel >= 2'd2) ? 2'd0 : sel + 2'd1;
               end else if (deq_data.finish) begin
                  phase_in = PH_CONFIRM;
               end
               if (moving) begin
                  action_dl_in = now + {16'h0000, repeat_dly_ff};
               end
            end else if (!moving) begin
               action_dl_in = now;
            end
            if (reached(now, blink_dl_ff)) begin
               blink_dl_in   = now + {16'h0000, blink_dly_ff};
               blink_step_in = (blink_step_ff > 3'd3) ? 3'd0 : blink_step_ff + 3'd1;
            end
            g[0] = seg_glyph(entered_in[0]);
            g[1] = seg_glyph(entered_in[1]);
            g[2] = seg_glyph(entered_in[2]);
            if (deq_data.report_path) begin
               res_in.select_report = sel_report(sel);
            end else if (blink_step_in == 3'd0) begin
               case (sel)
                  2'd0: g[0] = 7'h00;
                  2'd1: g[1] = 7'h00;
                  2'd2: g[2] = 7'h00;
                  default: ;
               endcase
            end
         end
         PH_CONFIRM: begin
            res_in.busy_res  = 1'b1;
            res_in.show_kind = SHOW_CLEAR;
            if (enabling_ff) begin
               saved_in             = entered_ff;
               locked_in            = 1'b1;
               res_in.saved_changed = 1'b1;
               phase_in             = PH_IDLE;
            end else if (code_match) begin
               locked_in            = 1'b0;
               res_in.saved_changed = 1'b1;
               phase_in             = PH_IDLE;
            end else begin
               phase_in             = PH_PREPARE;
               action_dl_in         = now + {16'h0000, prompt_dly_ff};
               res_in.code_mismatch = 1'b1;
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase

      res_in.glyph_first  = g[0];
      res_in.glyph_second = g[1];
      res_in.glyph_third  = g[2];
      res_in.lock_on      = locked_in;
      res_in.lock_code    = {saved_in[0], saved_in[1], saved_in[2]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         enabling_ff   <= 1'b0;
         entered_ff    <= '{default: 4'd0};
         cursor_ff     <= 2'd0;
         action_dl_ff  <= 32'd0;
         blink_dl_ff   <= 32'd0;
         blink_step_ff <= 3'd0;
         locked_ff     <= 1'b0;
         saved_ff      <= '{default: 4'd0};
         out_valid_ff  <= 1'b0;
      end else begin
         if (pop) begin
            phase_ff      <= phase_in;
            enabling_ff   <= enabling_in;
            entered_ff    <= entered_in;
            cursor_ff     <= cursor_in;
            action_dl_ff  <= action_dl_in;
            blink_dl_ff   <= blink_dl_in;
            blink_step_ff <= blink_step_in;
            locked_ff     <= locked_in;
            saved_ff      <= saved_in;
         end
         if (deq_ready) begin
            out_valid_ff <= deq_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         res_ff <= res_in;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.busy_res       = res_ff.busy_res;
   assign rsp.show_kind      = res_ff.show_kind;
   assign rsp.glyph_first    = res_ff.glyph_first;
   assign rsp.glyph_second   = res_ff.glyph_second;
   assign rsp.glyph_third    = res_ff.glyph_third;
   assign rsp.select_report  = res_ff.select_report;
   assign rsp.native_command = res_ff.native_command;
   assign rsp.saved_changed  = res_ff.saved_changed;
   assign rsp.code_mismatch  = res_ff.code_mismatch;
   assign rsp.lock_on        = res_ff.lock_on;
   assign rsp.lock_code      = res_ff.lock_code;

   `TDL_ASSERT_NEXT(a_lock_only_on_pop, clock, reset, !pop, $stable(locked_ff))
   `TDL_ASSERT_NEXT(a_enable_sets_lock, clock, reset, en_pop, locked_ff && phase_ff == PH_IDLE)
   `TDL_ASSERT_NEXT(a_mismatch_reprompt, clock, reset, bad_pop, locked_ff && phase_ff == PH_PREPARE)
   `TDL_ASSERT_NEXT(a_pop_gives_beat, clock, reset, pop, out_valid_ff)

endmodule
